>>> src/tgs_pkg.sv
package tgs_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS = 24;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int QUOT_WIDTH = PROD_WIDTH - FRAC_BITS;
    localparam int GAIN_WIDTH = 31;
    localparam int COEF_WIDTH = 25;
    localparam int APB_WIDTH = 32;
    localparam int ADDR_WIDTH = 5;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    localparam data_t MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t ONE = data_t'(64'd1 << FRAC_BITS);
    localparam data_t NEG_ONE = -ONE;
    localparam longint TENTH_VAL = (((longint'(2) << FRAC_BITS) / 10) + 1) / 2;
    localparam data_t TENTH = data_t'(TENTH_VAL);
    localparam data_t ZERO = '0;

    typedef enum logic [2:0] {
        REG_DROOP_GAIN    = 3'd0,
        REG_HP_FRACTION   = 3'd1,
        REG_SERVO_LAG     = 3'd2,
        REG_INV_VALVE     = 3'd3,
        REG_TIME_STEP     = 3'd4,
        REG_TURBINE_LAG   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0] droop_gain;
        logic [COEF_WIDTH-1:0] high_pressure_fraction;
        logic [COEF_WIDTH-1:0] servo_lag_coeff;
        logic [GAIN_WIDTH-1:0] inverse_valve_time;
        logic [COEF_WIDTH-1:0] time_step;
        logic [COEF_WIDTH-1:0] turbine_lag_coeff;
    } cfg_t;

    typedef struct packed {
        logic mul_en;
        logic sub;
    } arith_ctl_t;

endpackage

>>> src/turbine_governor_step_unit.sv
// Channel   Direction  Handshake                   Payload
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
// item      in         item_valid / item_stall     command, speed, speed_ref,
//                                                  power_ref, initial_torque
// result    out        result_valid / result_stall torque
//
// A time step request runs seven products and nine saturating sums one after
// another through the single multiplier and adder; no new request is taken in
// until it is done. An initialize request runs one product and one sum.
// Reset clears the configuration registers and the three governor states to zero.
// A result waits in the output register while the next request is taken in.
module turbine_governor_step_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tgs_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [tgs_pkg::APB_WIDTH-1:0]      pwdata,
    output logic [tgs_pkg::APB_WIDTH-1:0]      prdata,
    output logic                               pready,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               command,
    input  tgs_pkg::data_t                     speed,
    input  tgs_pkg::data_t                     speed_ref,
    input  tgs_pkg::data_t                     power_ref,
    input  tgs_pkg::data_t                     initial_torque,
    output logic                               result_valid,
    input  logic                               result_stall,
    output tgs_pkg::data_t                     torque
);
    import tgs_pkg::*;

    typedef enum logic [20:0] {
        ST_IDLE      = 21'h000001,
        ST_ERR       = 21'h000002,
        ST_M_GAIN    = 21'h000004,
        ST_RELAY     = 21'h000008,
        ST_SERVO_ERR = 21'h000010,
        ST_M_SERVO   = 21'h000020,
        ST_SERVO_UPD = 21'h000040,
        ST_VALVE_ERR = 21'h000080,
        ST_M_RATE    = 21'h000100,
        ST_RATE_LIM  = 21'h000200,
        ST_M_STEP    = 21'h000400,
        ST_VALVE_UPD = 21'h000800,
        ST_M_REST    = 21'h001000,
        ST_LAG_ERR   = 21'h002000,
        ST_M_LAG     = 21'h004000,
        ST_LAG_UPD   = 21'h008000,
        ST_M_FA      = 21'h010000,
        ST_TORQUE    = 21'h020000,
        ST_INIT_MUL  = 21'h040000,
        ST_INIT_LAG  = 21'h080000,
        ST_DONE      = 21'h100000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    cfg_t       cfg;
    arith_ctl_t ctl;
    data_t      mul_a;
    data_t      mul_b;
    data_t      add_x;
    data_t      add_y;
    data_t      prod_q;
    data_t      sum;
    data_t      fa;
    data_t      rest;

    data_t speed_reg;
    data_t speed_ref_reg;
    data_t power_ref_reg;
    data_t init_torque_reg;
    data_t t_reg;
    data_t t_next;
    data_t servo_reg;
    data_t servo_next;
    data_t valve_reg;
    data_t valve_next;
    data_t lag_reg;
    data_t lag_next;
    data_t torque_reg;
    logic  result_valid_reg;
    logic  result_valid_next;
    logic  load_result;
    logic  accept;

    tgs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgs_arith u_arith (
        .clk    (clk),
        .ctl    (ctl),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .add_x  (add_x),
        .add_y  (add_y),
        .prod_q (prod_q),
        .sum    (sum)
    );

    assign fa = data_t'(cfg.high_pressure_fraction);
    assign rest = ONE - fa;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept = item_valid && !item_stall;
    assign load_result = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign torque = torque_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        mul_a = t_reg;
        mul_b = t_reg;
        add_x = ZERO;
        add_y = prod_q;
        t_next = t_reg;
        servo_next = servo_reg;
        valve_next = valve_reg;
        lag_next = lag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = command ? ST_INIT_MUL : ST_ERR;
                end
            end
            ST_ERR:
            begin
                add_x = speed_ref_reg;
                add_y = speed_reg;
                ctl.sub = 1'b1;
                t_next = sum;
                state_next = ST_M_GAIN;
            end
            ST_M_GAIN:
            begin
                mul_b = data_t'(cfg.droop_gain);
                ctl.mul_en = 1'b1;
                state_next = ST_RELAY;
            end
            ST_RELAY:
            begin
                add_x = power_ref_reg;
                t_next = sum;
                state_next = ST_SERVO_ERR;
            end
            ST_SERVO_ERR:
            begin
                add_x = t_reg;
                add_y = servo_reg;
                ctl.sub = 1'b1;
                t_next = sum;
                state_next = ST_M_SERVO;
            end
            ST_M_SERVO:
            begin
                mul_a = data_t'(cfg.servo_lag_coeff);
                ctl.mul_en = 1'b1;
                state_next = ST_SERVO_UPD;
            end
            ST_SERVO_UPD:
            begin
                add_x = servo_reg;
                servo_next = sum;
                state_next = ST_VALVE_ERR;
            end
            ST_VALVE_ERR:
            begin
                add_x = servo_reg;
                add_y = valve_reg;
                ctl.sub = 1'b1;
                t_next = sum;
                state_next = ST_M_RATE;
            end
            ST_M_RATE:
            begin
                mul_b = data_t'(cfg.inverse_valve_time);
                ctl.mul_en = 1'b1;
                state_next = ST_RATE_LIM;
            end
            ST_RATE_LIM:
            begin
                if (prod_q >= TENTH)
                begin
                    t_next = TENTH;
                end
                else if (prod_q <= NEG_ONE)
                begin
                    t_next = NEG_ONE;
                end
                else
                begin
                    t_next = prod_q;
                end
                state_next = ST_M_STEP;
            end
            ST_M_STEP:
            begin
                mul_a = data_t'(cfg.time_step);
                ctl.mul_en = 1'b1;
                state_next = ST_VALVE_UPD;
            end
            ST_VALVE_UPD:
            begin
                add_x = valve_reg;
                if (sum >= ONE)
                begin
                    valve_next = ONE;
                end
                else if (sum <= ZERO)
                begin
                    valve_next = ZERO;
                end
                else
                begin
                    valve_next = sum;
                end
                state_next = ST_M_REST;
            end
            ST_M_REST:
            begin
                mul_a = rest;
                mul_b = valve_reg;
                ctl.mul_en = 1'b1;
                state_next = ST_LAG_ERR;
            end
            ST_LAG_ERR:
            begin
                add_x = prod_q;
                add_y = lag_reg;
                ctl.sub = 1'b1;
                t_next = sum;
                state_next = ST_M_LAG;
            end
            ST_M_LAG:
            begin
                mul_a = data_t'(cfg.turbine_lag_coeff);
                ctl.mul_en = 1'b1;
                state_next = ST_LAG_UPD;
            end
            ST_LAG_UPD:
            begin
                add_x = lag_reg;
                lag_next = sum;
                state_next = ST_M_FA;
            end
            ST_M_FA:
            begin
                mul_a = valve_reg;
                mul_b = fa;
                ctl.mul_en = 1'b1;
                state_next = ST_TORQUE;
            end
            ST_TORQUE:
            begin
                add_x = lag_reg;
                t_next = sum;
                state_next = ST_DONE;
            end
            ST_INIT_MUL:
            begin
                mul_a = rest;
                mul_b = power_ref_reg;
                ctl.mul_en = 1'b1;
                state_next = ST_INIT_LAG;
            end
            ST_INIT_LAG:
            begin
                lag_next = sum;
                servo_next = power_ref_reg;
                valve_next = power_ref_reg;
                t_next = init_torque_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            result_valid_reg <= 1'b0;
            servo_reg <= ZERO;
            valve_reg <= ZERO;
            lag_reg <= ZERO;
        end
        else
        begin
            state_reg <= state_next;
            result_valid_reg <= result_valid_next;
            servo_reg <= servo_next;
            valve_reg <= valve_next;
            lag_reg <= lag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            speed_reg <= speed;
            speed_ref_reg <= speed_ref;
            power_ref_reg <= power_ref;
            init_torque_reg <= initial_torque;
        end
        t_reg <= t_next;
        if (load_result)
        begin
            torque_reg <= t_reg;
        end
    end

endmodule

>>> src/tgs_cfg.sv
module tgs_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tgs_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [tgs_pkg::APB_WIDTH-1:0]      pwdata,
    output logic [tgs_pkg::APB_WIDTH-1:0]      prdata,
    output logic                               pready,
    output tgs_pkg::cfg_t                      cfg
);
    import tgs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DROOP_GAIN:  cfg_next.droop_gain = pwdata[GAIN_WIDTH-1:0];
                REG_HP_FRACTION: cfg_next.high_pressure_fraction = pwdata[COEF_WIDTH-1:0];
                REG_SERVO_LAG:   cfg_next.servo_lag_coeff = pwdata[COEF_WIDTH-1:0];
                REG_INV_VALVE:   cfg_next.inverse_valve_time = pwdata[GAIN_WIDTH-1:0];
                REG_TIME_STEP:   cfg_next.time_step = pwdata[COEF_WIDTH-1:0];
                REG_TURBINE_LAG: cfg_next.turbine_lag_coeff = pwdata[COEF_WIDTH-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DROOP_GAIN:
                prdata = APB_WIDTH'(cfg_reg.droop_gain);
            REG_HP_FRACTION:
                prdata = APB_WIDTH'(cfg_reg.high_pressure_fraction);
            REG_SERVO_LAG:
                prdata = APB_WIDTH'(cfg_reg.servo_lag_coeff);
            REG_INV_VALVE:
                prdata = APB_WIDTH'(cfg_reg.inverse_valve_time);
            REG_TIME_STEP:
                prdata = APB_WIDTH'(cfg_reg.time_step);
            REG_TURBINE_LAG:
                prdata = APB_WIDTH'(cfg_reg.turbine_lag_coeff);
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> src/tgs_arith.sv
module tgs_arith (
    input  logic                  clk,
    input  tgs_pkg::arith_ctl_t   ctl,
    input  tgs_pkg::data_t        mul_a,
    input  tgs_pkg::data_t        mul_b,
    input  tgs_pkg::data_t        add_x,
    input  tgs_pkg::data_t        add_y,
    output tgs_pkg::data_t        prod_q,
    output tgs_pkg::data_t        sum
);
    import tgs_pkg::*;

    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [PROD_WIDTH-1:0] prod_reg;
    logic                  neg_reg;
    logic [QUOT_WIDTH-1:0] quot;
    logic [QUOT_WIDTH-1:0] lim;
    logic [DATA_WIDTH-1:0] quot_lo;
    logic signed [DATA_WIDTH:0] ext_sum;

    // Products are formed on magnitudes so that the shift truncates toward zero.
    assign mag_a = mul_a[DATA_WIDTH-1] ? (~mul_a + 1'b1) : mul_a;
    assign mag_b = mul_b[DATA_WIDTH-1] ? (~mul_b + 1'b1) : mul_b;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= PROD_WIDTH'(mag_a) * PROD_WIDTH'(mag_b);
            neg_reg <= mul_a[DATA_WIDTH-1] ^ mul_b[DATA_WIDTH-1];
        end
    end

    assign quot = prod_reg[PROD_WIDTH-1:FRAC_BITS];
    assign lim = QUOT_WIDTH'(MAXV) + QUOT_WIDTH'(neg_reg);
    assign quot_lo = quot[DATA_WIDTH-1:0];

    always_comb
    begin
        if (quot > lim)
        begin
            prod_q = neg_reg ? MINV : MAXV;
        end
        else if (neg_reg)
        begin
            prod_q = data_t'(~quot_lo + 1'b1);
        end
        else
        begin
            prod_q = data_t'(quot_lo);
        end
    end

    always_comb
    begin
        if (ctl.sub)
        begin
            ext_sum = {add_x[DATA_WIDTH-1], add_x} - {add_y[DATA_WIDTH-1], add_y};
        end
        else
        begin
            ext_sum = {add_x[DATA_WIDTH-1], add_x} + {add_y[DATA_WIDTH-1], add_y};
        end
        if (ext_sum[DATA_WIDTH] != ext_sum[DATA_WIDTH-1])
        begin
            sum = ext_sum[DATA_WIDTH] ? MINV : MAXV;
        end
        else
        begin
            sum = ext_sum[DATA_WIDTH-1:0];
        end
    end

endmodule
